/* rtl/core/lzsw_pkg.sv */
// Shared types, constants and the microcode program of the short-window LZ decompressor.
// The top level, sequencer and datapath refer to this package by scoped names.
`default_nettype none

package lzsw_pkg;

	// Saturation value of the 32-bit counters.
	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	// Configuration address: bit APB_AW-1 selects the 32-bit register.
	localparam int          APB_AW         = 3;
	localparam logic        REG_SIZE_BE    = 1'b0;

	// Token nibble escape, length extension escape, minimum match and offset bias.
	localparam logic [3:0]  NIB_ESC        = 4'hF;
	localparam logic [7:0]  LEN_ESC        = 8'hFF;
	localparam logic [31:0] MATCH_MIN      = 32'd3;
	localparam logic [8:0]  OFFSET_BIAS    = 9'd4;

	// Stream parsing phase, one-hot.
	typedef enum logic [6:0] {
		PH_HEADER = 7'b0000001,
		PH_TOKEN  = 7'b0000010,
		PH_LITEXT = 7'b0000100,
		PH_LIT    = 7'b0001000,
		PH_OFFSET = 7'b0010000,
		PH_MEXT   = 7'b0100000,
		PH_COPY   = 7'b1000000
	} phase_t;

	// Datapath operations selected by the control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_HDR,
		OP_TOK,
		OP_LK,
		OP_LITEXT,
		OP_LIT,
		OP_OFF,
		OP_MEXT,
		OP_MSTART,
		OP_BINIT,
		OP_HRD,
		OP_BEM,
		OP_ST_DONE,
		OP_ST_ERR,
		OP_ST_PEND
	} op_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NIB_HI15,
		C_NIB_LO15,
		C_B_NOT255,
		C_ZERO_STREAM,
		C_DIST_BAD,
		C_BURST_MORE
	} cond_t;

	// Step counter and program addresses.
	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_HDR    = 4'd1;
	localparam step_t ST_TOK    = 4'd2;
	localparam step_t ST_LK     = 4'd3;
	localparam step_t ST_SDONE  = 4'd4;
	localparam step_t ST_LITEXT = 4'd5;
	localparam step_t ST_LIT    = 4'd6;
	localparam step_t ST_OFF    = 4'd7;
	localparam step_t ST_MSTART = 4'd8;
	localparam step_t ST_BINIT  = 4'd9;
	localparam step_t ST_BRD    = 4'd10;
	localparam step_t ST_BEM    = 4'd11;
	localparam step_t ST_SERR   = 4'd12;
	localparam step_t ST_MEXT   = 4'd13;
	localparam step_t ST_SPEND  = 4'd14;

	// One control word of the program.
	typedef struct packed {
		op_t   op;
		logic  emit;
		cond_t cond;
		step_t target;
		logic  fall_idle;
	} ctrl_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic en;
		logic emit;
		op_t  op;
	} dp_ctrl_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		phase_t phase;
		logic   nib_hi15;
		logic   nib_lo15;
		logic   b_not255;
		logic   zero_stream;
		logic   dist_bad;
		logic   burst_more;
		logic   out_free;
	} dp_stat_t;

	// Saturating 32-bit add.
	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? CNT_MAX : s[31:0];
	endfunction

	function automatic ctrl_t mk(input op_t op, input logic emit, input cond_t cond,
			input step_t target, input logic fall_idle);
		ctrl_t w;
		w.op        = op;
		w.emit      = emit;
		w.cond      = cond;
		w.target    = target;
		w.fall_idle = fall_idle;
		return w;
	endfunction

	// Microcode program. A taken jump goes to target; otherwise the step
	// falls through to the next address, or back to idle when fall_idle is set.
	function automatic ctrl_t ucode_rom(input step_t pc);
		ctrl_t w;
		unique case (pc)
			ST_IDLE:   w = mk(OP_NOP,      1'b0, C_NEVER,       ST_IDLE,   1'b1);
			ST_HDR:    w = mk(OP_HDR,      1'b0, C_ALWAYS,      ST_IDLE,   1'b1);
			ST_TOK:    w = mk(OP_TOK,      1'b0, C_NIB_HI15,    ST_IDLE,   1'b0);
			ST_LK:     w = mk(OP_LK,       1'b0, C_ZERO_STREAM, ST_SDONE,  1'b1);
			ST_SDONE:  w = mk(OP_ST_DONE,  1'b1, C_ALWAYS,      ST_IDLE,   1'b1);
			ST_LITEXT: w = mk(OP_LITEXT,   1'b0, C_B_NOT255,    ST_LK,     1'b1);
			ST_LIT:    w = mk(OP_LIT,      1'b1, C_ALWAYS,      ST_IDLE,   1'b1);
			ST_OFF:    w = mk(OP_OFF,      1'b0, C_NIB_LO15,    ST_IDLE,   1'b0);
			ST_MSTART: w = mk(OP_MSTART,   1'b0, C_DIST_BAD,    ST_SERR,   1'b0);
			ST_BINIT:  w = mk(OP_BINIT,    1'b0, C_NEVER,       ST_IDLE,   1'b0);
			ST_BRD:    w = mk(OP_HRD,      1'b0, C_NEVER,       ST_IDLE,   1'b0);
			ST_BEM:    w = mk(OP_BEM,      1'b1, C_BURST_MORE,  ST_BRD,    1'b1);
			ST_SERR:   w = mk(OP_ST_ERR,   1'b1, C_ALWAYS,      ST_IDLE,   1'b1);
			ST_MEXT:   w = mk(OP_MEXT,     1'b0, C_B_NOT255,    ST_MSTART, 1'b1);
			ST_SPEND:  w = mk(OP_ST_PEND,  1'b1, C_ALWAYS,      ST_IDLE,   1'b1);
			default:   w = mk(OP_NOP,      1'b0, C_ALWAYS,      ST_IDLE,   1'b1);
		endcase
		return w;
	endfunction

	// Entry step for an accepted transaction.
	function automatic step_t dispatch(input logic kind, input phase_t ph);
		step_t s;
		if (kind) begin
			s = (ph == PH_COPY) ? ST_BINIT : ST_IDLE;
		end else begin
			unique case (ph)
				PH_HEADER: s = ST_HDR;
				PH_TOKEN:  s = ST_TOK;
				PH_LITEXT: s = ST_LITEXT;
				PH_LIT:    s = ST_LIT;
				PH_OFFSET: s = ST_OFF;
				PH_MEXT:   s = ST_MEXT;
				PH_COPY:   s = ST_SPEND;
				default:   s = ST_IDLE;
			endcase
		end
		return s;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/lzsw_if.sv */
// Valid/ready channel interfaces for the compressed input and the decompressed output.
// Stand-alone; no package needed.
`default_nettype none

interface lzsw_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface lzsw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       copy_pending;
	logic       stream_done;
	logic       error;

	modport source (output valid, output out_byte, output last, output copy_pending,
		output stream_done, output error, input ready);
	modport sink   (input valid, input out_byte, input last, input copy_pending,
		input stream_done, input error, output ready);
endinterface

`default_nettype wire

/* rtl/core/lz_short_window_decompressor.sv */
// Top level of the short-window LZ decompressor: configuration port, sequencer and datapath.
// Depends on lzsw_pkg, lzsw_if, lzsw_useq and lzsw_datapath.
//
// The block decodes an LZ4-style stream with one-byte offsets: a four-byte size header,
// then sequences of token, length extensions, literals, offset and match. One input
// transaction is taken at a time. A literal or copied byte waits for any output stall, and
// a match runs its setup steps and then copies byte by byte, since every copied byte goes
// through the registered read port of the history ring before it is written back and
// sent out. A match longer than MAX_BURST bytes stops after MAX_BURST bytes with
// copy_pending set and resumes on a continue transaction. There is no clearing pass after
// reset. The size byte order register sits at address 0 and resets to big endian.
`default_nettype none

module lz_short_window_decompressor #(
	parameter int HISTORY_DEPTH = 512,
	parameter int MAX_BURST     = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	lzsw_in_if.sink                      in_stream,
	lzsw_out_if.source                   out_stream,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [lzsw_pkg::APB_AW-1:0]  paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic               size_be_q;
	logic               cfg_wr;
	logic               reg_hit;
	logic               in_accept;
	lzsw_pkg::dp_ctrl_t ctrl;
	lzsw_pkg::dp_stat_t stat;

	// Configuration register access.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[lzsw_pkg::APB_AW-1] == lzsw_pkg::REG_SIZE_BE);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? {31'd0, size_be_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_be_q <= 1'b1;
		end else if (cfg_wr) begin
			size_be_q <= pwdata[0];
		end
	end

	assign in_accept = in_stream.valid && in_stream.ready;

	lzsw_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_stream.valid),
		.in_kind  (in_stream.kind),
		.in_ready (in_stream.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	lzsw_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.MAX_BURST     (MAX_BURST)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.size_big_endian  (size_be_q),
		.in_accept        (in_accept),
		.in_byte          (in_stream.data_byte),
		.ctrl             (ctrl),
		.stat             (stat),
		.out_valid        (out_stream.valid),
		.out_ready        (out_stream.ready),
		.out_byte         (out_stream.out_byte),
		.out_last         (out_stream.last),
		.out_copy_pending (out_stream.copy_pending),
		.out_stream_done  (out_stream.stream_done),
		.out_error        (out_stream.error)
	);

endmodule

`default_nettype wire

/* rtl/core/lzsw_useq.sv */
// Microcoded sequencer: step counter, program table lookup and jump logic.
// Uses lzsw_pkg for the program, control word and status types.
`default_nettype none

module lzsw_useq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_kind,
	output logic                in_ready,
	input  lzsw_pkg::dp_stat_t  stat,
	output lzsw_pkg::dp_ctrl_t  ctrl
);

	lzsw_pkg::step_t pc_q;
	lzsw_pkg::ctrl_t word;
	logic            cond_true;
	logic            stall;

	// Decode the current control word and evaluate its jump condition.
	always_comb begin
		word = lzsw_pkg::ucode_rom(pc_q);
		unique case (word.cond)
			lzsw_pkg::C_NEVER:       cond_true = 1'b0;
			lzsw_pkg::C_ALWAYS:      cond_true = 1'b1;
			lzsw_pkg::C_NIB_HI15:    cond_true = stat.nib_hi15;
			lzsw_pkg::C_NIB_LO15:    cond_true = stat.nib_lo15;
			lzsw_pkg::C_B_NOT255:    cond_true = stat.b_not255;
			lzsw_pkg::C_ZERO_STREAM: cond_true = stat.zero_stream;
			lzsw_pkg::C_DIST_BAD:    cond_true = stat.dist_bad;
			lzsw_pkg::C_BURST_MORE:  cond_true = stat.burst_more;
			default:                 cond_true = 1'b0;
		endcase
		// A step that emits waits until the output register can take a result.
		stall     = word.emit && !stat.out_free;
		ctrl.en   = (pc_q != lzsw_pkg::ST_IDLE) && !stall;
		ctrl.emit = word.emit;
		ctrl.op   = word.op;
		in_ready  = (pc_q == lzsw_pkg::ST_IDLE);
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= lzsw_pkg::ST_IDLE;
		end else if (pc_q == lzsw_pkg::ST_IDLE) begin
			if (in_valid) begin
				pc_q <= lzsw_pkg::dispatch(in_kind, stat.phase);
			end
		end else if (!stall) begin
			if (cond_true) begin
				pc_q <= word.target;
			end else if (word.fall_idle) begin
				pc_q <= lzsw_pkg::ST_IDLE;
			end else begin
				pc_q <= pc_q + 4'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/lzsw_datapath.sv */
// Datapath: stream state registers, history ring memory and the output register.
// Uses lzsw_pkg for the control and status structs, phases and constants.
`default_nettype none

module lzsw_datapath #(
	parameter int HISTORY_DEPTH = 512,
	parameter int MAX_BURST     = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 size_big_endian,
	input  wire                 in_accept,
	input  wire  [7:0]          in_byte,
	input  lzsw_pkg::dp_ctrl_t  ctrl,
	output lzsw_pkg::dp_stat_t  stat,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output logic                out_copy_pending,
	output logic                out_stream_done,
	output logic                out_error
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int NW = $clog2(MAX_BURST);
	localparam logic [AW:0]   DEPTH_EXT  = (AW + 1)'(HISTORY_DEPTH);
	localparam logic [AW-1:0] WR_LAST    = AW'(HISTORY_DEPTH - 1);
	localparam logic [NW-1:0] BURST_LAST = NW'(MAX_BURST - 1);
	localparam logic [31:0]   BURST_MAX  = 32'(MAX_BURST);

	lzsw_pkg::phase_t phase_q;
	logic [1:0]       hc_q;
	logic [31:0]      size_q;
	logic [31:0]      prod_q;
	logic [7:0]       tok_q;
	logic [31:0]      lit_q;
	logic             final_q;
	logic [31:0]      ml_q;
	logic [8:0]       dist_q;
	logic [AW-1:0]    wr_q;
	logic [NW-1:0]    n_q;
	logic             pend_q;
	logic [7:0]       byte_q;
	logic [7:0]       rdata_q;
	logic [7:0]       hist_mem [HISTORY_DEPTH];

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic             out_pend_q;
	logic             out_done_q;
	logic             out_err_q;

	logic             fire;
	logic             emit_fire;
	logic [AW:0]      rd_sum;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_next;
	logic [31:0]      prod_inc;
	logic [33:0]      final_sum;
	logic             burst_last;
	logic             hist_we;
	logic             hist_re;
	logic [7:0]       hist_wdata;
	logic [7:0]       o_byte;
	logic             o_last;
	logic             o_pend;
	logic             o_done;
	logic             o_err;

	// Read address behind the write position, and shared increments.
	always_comb begin
		fire       = ctrl.en;
		emit_fire  = ctrl.en && ctrl.emit;
		rd_sum     = {1'b0, wr_q} + DEPTH_EXT - (AW + 1)'(dist_q);
		rd_addr    = (rd_sum >= DEPTH_EXT) ? AW'(rd_sum - DEPTH_EXT) : rd_sum[AW-1:0];
		wr_next    = (wr_q == WR_LAST) ? '0 : wr_q + 1'b1;
		prod_inc   = lzsw_pkg::sat_add32(prod_q, 32'd1);
		final_sum  = {2'b00, prod_q} + {2'b00, lit_q} + 34'd4;
		burst_last = (ml_q == 32'd1) || (n_q == BURST_LAST);
		hist_we    = fire && ((ctrl.op == lzsw_pkg::OP_LIT) || (ctrl.op == lzsw_pkg::OP_BEM));
		hist_re    = fire && (ctrl.op == lzsw_pkg::OP_HRD);
		hist_wdata = (ctrl.op == lzsw_pkg::OP_LIT) ? byte_q : rdata_q;
	end

	// Status for the sequencer's jump conditions.
	always_comb begin
		stat.phase       = phase_q;
		stat.nib_hi15    = (byte_q[7:4] == lzsw_pkg::NIB_ESC);
		stat.nib_lo15    = (tok_q[3:0] == lzsw_pkg::NIB_ESC);
		stat.b_not255    = (byte_q != lzsw_pkg::LEN_ESC);
		stat.zero_stream = (lit_q == 32'd0) && (size_q == 32'd0);
		stat.dist_bad    = (32'(dist_q) > prod_q);
		stat.burst_more  = !burst_last;
		stat.out_free    = !out_valid_q || out_ready;
	end

	// Result fields for the emitting operations.
	always_comb begin
		o_byte = 8'd0;
		o_last = 1'b1;
		o_pend = 1'b0;
		o_done = 1'b0;
		o_err  = 1'b0;
		unique case (ctrl.op)
			lzsw_pkg::OP_LIT: begin
				o_byte = byte_q;
				o_done = (lit_q == 32'd1) && final_q;
			end
			lzsw_pkg::OP_BEM: begin
				o_byte = rdata_q;
				o_last = burst_last;
				o_pend = pend_q;
			end
			lzsw_pkg::OP_ST_DONE: begin
				o_done = 1'b1;
			end
			lzsw_pkg::OP_ST_ERR: begin
				o_err = 1'b1;
			end
			lzsw_pkg::OP_ST_PEND: begin
				o_pend = 1'b1;
				o_err  = 1'b1;
			end
			default: begin
				o_last = 1'b0;
			end
		endcase
	end

	// Latch the byte of each accepted transaction.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_q <= in_byte;
		end
	end

	// History ring: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[wr_q] <= hist_wdata;
		end
		if (hist_re) begin
			rdata_q <= hist_mem[rd_addr];
		end
	end

	// Stream state updated by the current operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lzsw_pkg::PH_HEADER;
			hc_q    <= 2'd0;
			size_q  <= 32'd0;
			prod_q  <= 32'd0;
			tok_q   <= 8'd0;
			lit_q   <= 32'd0;
			final_q <= 1'b0;
			ml_q    <= 32'd0;
			dist_q  <= 9'd0;
			wr_q    <= '0;
			n_q     <= '0;
			pend_q  <= 1'b0;
		end else if (fire) begin
			unique case (ctrl.op)
				lzsw_pkg::OP_HDR: begin
					if (size_big_endian) begin
						size_q <= (hc_q == 2'd0) ? {24'd0, byte_q} : {size_q[23:0], byte_q};
					end else begin
						unique case (hc_q)
							2'd0: size_q <= {24'd0, byte_q};
							2'd1: size_q <= {size_q[31:16], byte_q, size_q[7:0]};
							2'd2: size_q <= {size_q[31:24], byte_q, size_q[15:0]};
							2'd3: size_q <= {byte_q, size_q[23:0]};
							default: size_q <= size_q;
						endcase
					end
					hc_q <= hc_q + 2'd1;
					if (hc_q == 2'd3) begin
						prod_q  <= 32'd0;
						phase_q <= lzsw_pkg::PH_TOKEN;
					end
				end
				lzsw_pkg::OP_TOK: begin
					tok_q   <= byte_q;
					lit_q   <= {28'd0, byte_q[7:4]};
					final_q <= 1'b0;
					if (byte_q[7:4] == lzsw_pkg::NIB_ESC) begin
						phase_q <= lzsw_pkg::PH_LITEXT;
					end
				end
				lzsw_pkg::OP_LK: begin
					if (lit_q == 32'd0) begin
						if (size_q == 32'd0) begin
							phase_q <= lzsw_pkg::PH_HEADER;
							hc_q    <= 2'd0;
						end else begin
							phase_q <= lzsw_pkg::PH_OFFSET;
						end
					end else begin
						final_q <= (final_sum >= {2'b00, size_q});
						phase_q <= lzsw_pkg::PH_LIT;
					end
				end
				lzsw_pkg::OP_LITEXT: begin
					lit_q <= lzsw_pkg::sat_add32(lit_q, {24'd0, byte_q});
				end
				lzsw_pkg::OP_LIT: begin
					wr_q   <= wr_next;
					prod_q <= prod_inc;
					lit_q  <= lit_q - 32'd1;
					if (lit_q == 32'd1) begin
						if (final_q) begin
							final_q <= 1'b0;
							hc_q    <= 2'd0;
							phase_q <= lzsw_pkg::PH_HEADER;
						end else begin
							phase_q <= lzsw_pkg::PH_OFFSET;
						end
					end
				end
				lzsw_pkg::OP_OFF: begin
					dist_q <= {1'b0, byte_q} + lzsw_pkg::OFFSET_BIAS;
					ml_q   <= {28'd0, tok_q[3:0]};
					if (tok_q[3:0] == lzsw_pkg::NIB_ESC) begin
						phase_q <= lzsw_pkg::PH_MEXT;
					end
				end
				lzsw_pkg::OP_MEXT: begin
					ml_q <= lzsw_pkg::sat_add32(ml_q, {24'd0, byte_q});
				end
				lzsw_pkg::OP_MSTART: begin
					// An offset reaching before the stream start drops the match.
					if (32'(dist_q) > prod_q) begin
						ml_q    <= 32'd0;
						phase_q <= lzsw_pkg::PH_TOKEN;
					end else begin
						ml_q <= lzsw_pkg::sat_add32(ml_q, lzsw_pkg::MATCH_MIN);
					end
				end
				lzsw_pkg::OP_BINIT: begin
					n_q    <= '0;
					pend_q <= (ml_q > BURST_MAX);
				end
				lzsw_pkg::OP_BEM: begin
					wr_q   <= wr_next;
					prod_q <= prod_inc;
					ml_q   <= ml_q - 32'd1;
					n_q    <= n_q + 1'b1;
					if (burst_last) begin
						phase_q <= pend_q ? lzsw_pkg::PH_COPY : lzsw_pkg::PH_TOKEN;
					end
				end
				default: begin
					phase_q <= phase_q;
				end
			endcase
		end
	end

	// Output register: holds one result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_byte_q <= o_byte;
			out_last_q <= o_last;
			out_pend_q <= o_pend;
			out_done_q <= o_done;
			out_err_q  <= o_err;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_byte         = out_byte_q;
	assign out_last         = out_last_q;
	assign out_copy_pending = out_pend_q;
	assign out_stream_done  = out_done_q;
	assign out_error        = out_err_q;

endmodule

`default_nettype wire

/* verif/lz_short_window_decompressor_test.sv */
// Self-checking testbench for lz_short_window_decompressor: directed table, then random streams.
// Depends on lzsw_pkg, the lzsw_in_if and lzsw_out_if interfaces and the decompressor RTL.
`default_nettype none

module lz_short_window_decompressor_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lzsw_pkg::*;

	localparam int HIST_DEPTH      = 512;
	localparam int BURST_MAX       = 64;
	localparam int CLK_PERIOD      = 10;
	localparam int RANDOM_ITEMS    = 130;
	localparam int SETTLE_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int MAX_PRINTED     = 40;
	localparam logic [APB_AW-1:0] SIZE_ORDER_ADDR = APB_AW'(4 * int'(REG_SIZE_BE));

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       copy_pending;
		logic       stream_done;
		logic       error;
	} lz_result_t;

	// One row of the directed table; res is used only when typed is set.
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       typed;
		lz_result_t res;
	} step_row_t;

	localparam lz_result_t NO_RESULT        = '0;
	localparam lz_result_t ZERO_SIZE_END    = '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0};
	localparam lz_result_t OFFSET_ERROR     = '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1};
	localparam lz_result_t BUSY_ERROR       = '{8'h00, 1'b1, 1'b1, 1'b0, 1'b1};
	localparam lz_result_t FIRST_LITERAL_FF = '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0};

	// Zero-size stream, then a size-300 stream with an early bad offset, a long
	// overlapping match, a byte sent while the copy is pending and continues.
	step_row_t directed_steps [25] = '{
		'{1'b0, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 1'b1, ZERO_SIZE_END},
		'{1'b0, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h01, 1'b0, NO_RESULT},
		'{1'b0, 8'h2C, 1'b0, NO_RESULT},
		'{1'b0, 8'h10, 1'b0, NO_RESULT},
		'{1'b0, 8'hFF, 1'b1, FIRST_LITERAL_FF},
		'{1'b0, 8'h00, 1'b1, OFFSET_ERROR},
		'{1'b0, 8'h3F, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h80, 1'b0, NO_RESULT},
		'{1'b0, 8'h7F, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'hFF, 1'b0, NO_RESULT},
		'{1'b0, 8'h00, 1'b0, NO_RESULT},
		'{1'b0, 8'h5A, 1'b1, BUSY_ERROR},
		'{1'b1, 8'h00, 1'b0, NO_RESULT},
		'{1'b1, 8'hFF, 1'b0, NO_RESULT},
		'{1'b1, 8'h00, 1'b0, NO_RESULT},
		'{1'b1, 8'h00, 1'b0, NO_RESULT},
		'{1'b1, 8'h00, 1'b0, NO_RESULT}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lzsw_in_if  in_if();
	lzsw_out_if out_if();

	lz_short_window_decompressor #(
		.HISTORY_DEPTH(HIST_DEPTH),
		.MAX_BURST    (BURST_MAX)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_stream (in_if),
		.out_stream(out_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Decoder state mirrored by the predictor.
	logic        cfg_size_be = 1'b1;
	phase_t      dec_phase   = PH_HEADER;
	int          hdr_cnt     = 0;
	logic [31:0] size_hdr    = '0;
	logic [31:0] produced    = '0;
	logic [7:0]  token_byte  = '0;
	logic [31:0] lits_left   = '0;
	logic        final_seq   = 1'b0;
	logic [31:0] match_left  = '0;
	logic [8:0]  match_dist  = '0;
	int          wr_ptr      = 0;
	logic [7:0]  hist [HIST_DEPTH];

	lz_result_t  item_results[$];
	lz_result_t  expected_out[$];

	int          send_idle_pct;
	int          recv_idle_pct;
	int          stim_count   = 0;
	int          mismatches   = 0;
	int          checked      = 0;
	int          quiet_cycles = 0;
	lz_result_t  got;
	lz_result_t  want;

	function automatic logic [31:0] count_add(input logic [31:0] a, input logic [31:0] b);
		return (a > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : a + b;
	endfunction

	function automatic lz_result_t status_result(input logic pend, input logic done,
			input logic err);
		return '{out_byte: 8'h00, last: 1'b1, copy_pending: pend, stream_done: done, error: err};
	endfunction

	// A decompressed byte goes into the history ring and the produced count.
	function automatic void out_put(input logic [7:0] v);
		lz_result_t r;
		hist[wr_ptr] = v;
		wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
		produced = count_add(produced, 32'd1);
		r = '0;
		r.out_byte = v;
		item_results.push_back(r);
	endfunction

	// Copy up to one burst of match bytes; the rest waits for continues.
	function automatic void copy_burst();
		int   n;
		logic more;
		n = 0;
		while (match_left != 0 && n < BURST_MAX) begin
			out_put(hist[(wr_ptr + HIST_DEPTH - int'(match_dist)) % HIST_DEPTH]);
			match_left--;
			n++;
		end
		more = (match_left != 0);
		foreach (item_results[i]) item_results[i].copy_pending = more;
		item_results[item_results.size() - 1].last = 1'b1;
		dec_phase = more ? PH_COPY : PH_TOKEN;
	endfunction

	// A distance reaching back before the stream start drops the match.
	function automatic void begin_match();
		match_left = count_add(match_left, MATCH_MIN);
		if (match_dist > produced) begin
			match_left = '0;
			dec_phase = PH_TOKEN;
			item_results.push_back(status_result(1'b0, 1'b0, 1'b1));
		end else begin
			copy_burst();
		end
	endfunction

	// Literal count is complete: empty stream end, match only, or literals.
	function automatic void lits_resolved();
		if (lits_left == 0) begin
			if (size_hdr == 0) begin
				dec_phase = PH_HEADER;
				hdr_cnt = 0;
				item_results.push_back(status_result(1'b0, 1'b1, 1'b0));
			end else begin
				dec_phase = PH_OFFSET;
			end
		end else begin
			final_seq = (64'(produced) + 64'(lits_left) + 64'd4 >= 64'(size_hdr));
			dec_phase = PH_LIT;
		end
	endfunction

	// Predict the results of one accepted input transaction.
	function automatic void decode_item(input logic kind, input logic [7:0] b);
		item_results.delete();
		if (kind) begin
			if (dec_phase == PH_COPY) copy_burst();
			return;
		end
		case (dec_phase)
			PH_HEADER: begin
				if (hdr_cnt == 0) size_hdr = '0;
				if (cfg_size_be) size_hdr = {size_hdr[23:0], b};
				else size_hdr[8 * hdr_cnt +: 8] = b;
				hdr_cnt++;
				if (hdr_cnt >= 4) begin
					hdr_cnt = 0;
					produced = '0;
					dec_phase = PH_TOKEN;
				end
			end
			PH_TOKEN: begin
				token_byte = b;
				lits_left = 32'(b[7:4]);
				final_seq = 1'b0;
				if (b[7:4] == NIB_ESC) dec_phase = PH_LITEXT;
				else lits_resolved();
			end
			PH_LITEXT: begin
				lits_left = count_add(lits_left, 32'(b));
				if (b != LEN_ESC) lits_resolved();
			end
			PH_LIT: begin
				out_put(b);
				item_results[0].last = 1'b1;
				lits_left--;
				if (lits_left == 0) begin
					if (final_seq) begin
						item_results[0].stream_done = 1'b1;
						final_seq = 1'b0;
						hdr_cnt = 0;
						dec_phase = PH_HEADER;
					end else begin
						dec_phase = PH_OFFSET;
					end
				end
			end
			PH_OFFSET: begin
				match_dist = {1'b0, b} + OFFSET_BIAS;
				match_left = 32'(token_byte[3:0]);
				if (token_byte[3:0] == NIB_ESC) dec_phase = PH_MEXT;
				else begin_match();
			end
			PH_MEXT: begin
				match_left = count_add(match_left, 32'(b));
				if (b != LEN_ESC) begin_match();
			end
			PH_COPY: begin
				item_results.push_back(status_result(1'b1, 1'b0, 1'b1));
			end
			default: begin
				dec_phase = PH_HEADER;
				hdr_cnt = 0;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got_val, input int want_val);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch at result %0d: %s got %0d expected %0d", checked, what, got_val,
				want_val);
	endtask

	// Drive one input transaction, idling first at random, and predict its results.
	task automatic send_item(input logic kind, input logic [7:0] b, input logic typed = 1'b0,
			input lz_result_t typed_res = '0);
		while ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid     <= 1'b1;
		in_if.kind      <= kind;
		in_if.data_byte <= b;
		do @(posedge clk); while (!in_if.ready);
		if (!(kind && dec_phase != PH_COPY)) stim_count++;
		decode_item(kind, b);
		if (typed) expected_out.push_back(typed_res);
		else foreach (item_results[i]) expected_out.push_back(item_results[i]);
	endtask

	// Stop sending and let every expected result and any result-free work finish.
	task automatic drain_outputs();
		in_if.valid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == SIZE_ORDER_ADDR) cfg_size_be = value[0];
	endtask

	task automatic send_header(input logic [31:0] sz);
		for (int i = 0; i < 4; i++)
			send_item(1'b0, cfg_size_be ? sz[8 * (3 - i) +: 8] : sz[8 * i +: 8]);
	endtask

	// Length extension bytes: 255 while the rest is at least 255, then the remainder.
	task automatic send_len_ext(input int rest);
		while (rest >= 255) begin
			send_item(1'b0, LEN_ESC);
			rest -= 255;
		end
		send_item(1'b0, 8'(rest));
	endtask

	// One well-formed sequence from the token phase, with some noise and bad offsets.
	task automatic run_sequence();
		longint     room;
		int         lit_n;
		int         match_n;
		int         avail;
		int         off;
		int         pick;
		logic       is_final;
		logic [7:0] tok;
		room = longint'(size_hdr) - longint'(produced) - 64'sd4;
		if ($urandom_range(99) < 5) send_item(1'b1, 8'($urandom_range(255)));
		if ($urandom_range(99) < 3) drain_outputs();
		is_final = (room <= 0) || (room <= 40 && $urandom_range(99) < 30);
		if (is_final) begin
			if (size_hdr == 0 && $urandom_range(1) == 1) lit_n = 0;
			else lit_n = ((room < 1) ? 1 : int'(room)) + $urandom_range(2);
		end else if (room > 300 && $urandom_range(99) < 20) begin
			lit_n = $urandom_range(290, 270);
		end else begin
			lit_n = $urandom_range((room < 13) ? int'(room) - 1 : 12);
		end
		pick = $urandom_range(99);
		if (pick < 70) match_n = 3 + $urandom_range(12);
		else if (pick < 90) match_n = 15 + $urandom_range(45);
		else match_n = 60 + $urandom_range(90);

		tok[7:4] = (lit_n >= 15) ? NIB_ESC : 4'(lit_n);
		tok[3:0] = (match_n - 3 >= 15) ? NIB_ESC : 4'(match_n - 3);
		send_item(1'b0, tok);
		if (lit_n >= 15) send_len_ext(lit_n - 15);
		repeat (lit_n) send_item(1'b0, 8'($urandom_range(255)));
		if (is_final) return;

		// Mostly distances inside the stream, sometimes one reaching before it.
		avail = int'(produced);
		if (avail >= 4 && $urandom_range(99) >= 10)
			off = $urandom_range(((avail > 259) ? 259 : avail) - 4);
		else if (avail - 3 <= 255)
			off = $urandom_range(255, (avail - 3 < 0) ? 0 : avail - 3);
		else
			off = $urandom_range(255);
		send_item(1'b0, 8'(off));
		if (match_n - 3 >= 15) send_len_ext(match_n - 18);
		while (dec_phase == PH_COPY) begin
			if ($urandom_range(99) < 8) send_item(1'b0, 8'($urandom_range(255)));
			else send_item(1'b1, 8'($urandom_range(255)));
		end
	endtask

	// A stream of random size, mostly small; finishes an open stream first.
	task automatic run_stream();
		int          pick;
		logic [31:0] sz;
		pick = $urandom_range(99);
		if (pick < 10) sz = 0;
		else if (pick < 75) sz = $urandom_range(40, 1);
		else if (pick < 95) sz = $urandom_range(200, 41);
		else sz = $urandom_range(420, 201);
		if (dec_phase == PH_HEADER) begin
			if ($urandom_range(99) < 10) send_item(1'b1, 8'($urandom_range(255)));
			send_header(sz);
		end
		while (dec_phase != PH_HEADER) run_sequence();
	endtask

	// Receiver: random stalls, and each output transaction checked in order.
	always @(posedge clk) begin
		out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		if (out_if.valid && out_if.ready) begin
			got.out_byte     = out_if.out_byte;
			got.last         = out_if.last;
			got.copy_pending = out_if.copy_pending;
			got.stream_done  = out_if.stream_done;
			got.error        = out_if.error;
			if (expected_out.size() == 0) begin
				report_mismatch("unexpected result, out_byte", got.out_byte, -1);
			end else begin
				want = expected_out.pop_front();
				if (got.out_byte != want.out_byte)
					report_mismatch("out_byte", got.out_byte, want.out_byte);
				if (got.last != want.last)
					report_mismatch("last", got.last, want.last);
				if (got.copy_pending != want.copy_pending)
					report_mismatch("copy_pending", got.copy_pending, want.copy_pending);
				if (got.stream_done != want.stream_done)
					report_mismatch("stream_done", got.stream_done, want.stream_done);
				if (got.error != want.error)
					report_mismatch("error", got.error, want.error);
			end
			checked++;
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int base;
		arst_n          = 1'b0;
		in_if.valid     = 1'b0;
		in_if.kind      = 1'b0;
		in_if.data_byte = 8'h00;
		out_if.ready    = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		send_idle_pct   = 14;
		recv_idle_pct   = 68;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset byte order.
		foreach (directed_steps[i])
			send_item(directed_steps[i].kind, directed_steps[i].data_byte,
				directed_steps[i].typed, directed_steps[i].res);

		// Three random phases with different idling and byte orders.
		base = stim_count;
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			drain_outputs();
			write_reg(SIZE_ORDER_ADDR, (p == 1) ? 32'd1 : 32'd0);
			while (stim_count < base + RANDOM_ITEMS * (p + 1) / 3) run_stream();
		end

		// An all-ones size header keeps every sequence non-final.
		send_header(32'hFFFF_FFFF);
		repeat (3) run_sequence();

		drain_outputs();
		if (expected_out.size() != 0)
			report_mismatch("results left over", 0, expected_out.size());
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
